>>> design/lprd_pkg.sv
// Shared types, codes and helper functions of the length-prefixed request deframer.
package lprd_pkg;

	localparam int LEN_W = 26;
	localparam int IDX_W = 25;
	localparam int WORD_W = 32;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(4096);
	localparam logic [WORD_W-1:0] NAME_LEN = WORD_W'(3);

	localparam logic [23:0] NAME_GET = 24'h676574;
	localparam logic [23:0] NAME_SET = 24'h736574;
	localparam logic [23:0] NAME_DEL = 24'h64656c;

	localparam int MATCH_GET = 0;
	localparam int MATCH_SET = 1;
	localparam int MATCH_DEL = 2;
	localparam logic [2:0] MATCH_ALL = 3'b111;

	typedef enum logic [1:0] {
		VERDICT_NONE,
		VERDICT_OK,
		VERDICT_TOO_LONG,
		VERDICT_MALFORMED
	} verdict_t;

	typedef enum logic [1:0] {
		CMD_GET,
		CMD_SET,
		CMD_DEL,
		CMD_UNKNOWN
	} command_t;

	typedef struct packed {
		logic             have;
		logic             data_valid;
		logic [7:0]       data_byte;
		logic [IDX_W-1:0] string_index;
		logic             string_last;
		logic             frame_end;
		verdict_t         verdict;
		command_t         command;
	} result_t;

	function automatic logic [7:0] name_byte(input logic [23:0] name, input logic [1:0] pos);
		logic [7:0] sel;
		unique case (pos)
			2'd0: sel = name[23:16];
			2'd1: sel = name[15:8];
			default: sel = name[7:0];
		endcase
		return sel;
	endfunction

	function automatic command_t classify(input logic [LEN_W-1:0] total, input logic [2:0] match);
		command_t cmd;
		priority if (total == LEN_W'(2) && match[MATCH_GET]) begin
			cmd = CMD_GET;
		end else if (total == LEN_W'(3) && match[MATCH_SET]) begin
			cmd = CMD_SET;
		end else if (total == LEN_W'(2) && match[MATCH_DEL]) begin
			cmd = CMD_DEL;
		end else begin
			cmd = CMD_UNKNOWN;
		end
		return cmd;
	endfunction

endpackage

>>> design/length_prefixed_request_deframer.sv
// Top level of the length-prefixed request deframer: input stage, parser and result register.
// The block takes one stream byte per cycle unless stalled and gives at most one result per
// byte: the byte is held in the input register, then the parser updates its counters and
// forms the result into the output register. A byte is taken while an earlier result still
// waits, so the stream runs at one byte per clock as long as results are drained; a stalled
// result holds the input stage after one byte. The limit register max_message_length resets
// to 4096; the user writes it through the cfg port only while the block is idle, which the
// block does not enforce. A too-long or malformed frame closes the stream until reset.
module length_prefixed_request_deframer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [lprd_pkg::LEN_W-1:0] max_message_length,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 stream_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       data_valid,
	output logic [7:0]                 data_byte,
	output logic [lprd_pkg::IDX_W-1:0] string_index,
	output logic                       string_last,
	output logic                       frame_end,
	output logic [1:0]                 verdict,
	output logic [1:0]                 command
);
	import lprd_pkg::*;

	logic [LEN_W-1:0] max_len_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             out_valid_q;
	result_t          res_q;
	result_t          res;
	logic             advance;
	logic             step;

	assign cfg_ready = 1'b1;
	assign advance = !out_valid_q || !out_stall;
	assign step = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= max_message_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= stream_byte;
		end
	end

	lprd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.max_len (max_len_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= res.have;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign data_valid = res_q.data_valid;
	assign data_byte = res_q.data_byte;
	assign string_index = res_q.string_index;
	assign string_last = res_q.string_last;
	assign frame_end = res_q.frame_end;
	assign verdict = res_q.verdict;
	assign command = res_q.command;

endmodule

>>> design/lprd_parser.sv
// Frame parser: parse state registers and the per-byte step logic that forms one result.
module lprd_parser (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic [7:0]                byte_in,
	input  logic [lprd_pkg::LEN_W-1:0] max_len,
	output lprd_pkg::result_t         res
);
	import lprd_pkg::*;

	typedef enum logic [2:0] {
		ST_LEN,
		ST_CNT,
		ST_SLEN,
		ST_DATA,
		ST_TRAIL,
		ST_CLOSED
	} stage_t;

	stage_t            stage_q, stage_d;
	logic [1:0]        hcnt_q, hcnt_d;
	logic [23:0]       word_q, word_d;
	logic [LEN_W-1:0]  fbl_q, fbl_d;
	logic [LEN_W-1:0]  sleft_q, sleft_d;
	logic [LEN_W-1:0]  total_q, total_d;
	logic [LEN_W-1:0]  sbl_q, sbl_d;
	logic [IDX_W-1:0]  cur_q, cur_d;
	logic              err_q, err_d;
	logic [2:0]        match_q, match_d;

	logic [WORD_W-1:0] w;
	logic              hdr_done;
	logic              last;
	logic              ok;
	logic [1:0]        pos;
	logic              in_name;

	assign w = {byte_in, word_q};
	assign hdr_done = (hcnt_q == 2'd3);
	assign last = (fbl_q == LEN_W'(1));
	assign pos = 2'd3 - sbl_q[1:0];
	assign in_name = (cur_q == '0) && (sbl_q != '0) && (sbl_q[LEN_W-1:2] == '0);

	always_comb begin
		stage_d = stage_q;
		hcnt_d = hcnt_q;
		word_d = word_q;
		fbl_d = fbl_q;
		sleft_d = sleft_q;
		total_d = total_q;
		sbl_d = sbl_q;
		cur_d = cur_q;
		err_d = err_q;
		match_d = match_q;
		ok = 1'b0;
		res = '0;
		res.verdict = VERDICT_NONE;
		res.command = CMD_GET;

		if (step && stage_q != ST_CLOSED) begin
			if (stage_q == ST_CNT || stage_q == ST_SLEN || stage_q == ST_LEN) begin
				if (hdr_done) begin
					hcnt_d = 2'd0;
					word_d = '0;
				end else begin
					hcnt_d = hcnt_q + 2'd1;
					word_d = word_q | (24'(byte_in) << {hcnt_q, 3'b000});
				end
			end

			if (stage_q == ST_LEN) begin
				if (hdr_done) begin
					if (w == '0) begin
						stage_d = ST_CLOSED;
						res.have = 1'b1;
						res.frame_end = 1'b1;
						res.verdict = VERDICT_MALFORMED;
					end else if (w > WORD_W'(max_len)) begin
						stage_d = ST_CLOSED;
						res.have = 1'b1;
						res.frame_end = 1'b1;
						res.verdict = VERDICT_TOO_LONG;
					end else begin
						fbl_d = w[LEN_W-1:0];
						stage_d = ST_CNT;
						err_d = 1'b0;
						match_d = MATCH_ALL;
						sleft_d = '0;
						total_d = '0;
						cur_d = '0;
						sbl_d = '0;
					end
				end
			end else begin
				fbl_d = fbl_q - LEN_W'(1);
				unique case (stage_q)
					ST_CNT: begin
						if (hdr_done) begin
							if (w > WORD_W'(max_len)) begin
								err_d = 1'b1;
								stage_d = ST_TRAIL;
							end else begin
								sleft_d = w[LEN_W-1:0];
								total_d = w[LEN_W-1:0];
								cur_d = '0;
								stage_d = (w == '0) ? ST_TRAIL : ST_SLEN;
							end
						end
					end
					ST_SLEN: begin
						if (hdr_done) begin
							if (w >= WORD_W'(fbl_q)) begin
								err_d = 1'b1;
								stage_d = ST_TRAIL;
							end else begin
								if (cur_q == '0 && w != NAME_LEN) begin
									match_d = '0;
								end
								if (w == '0) begin
									res.have = 1'b1;
									res.string_index = cur_q;
									res.string_last = 1'b1;
									cur_d = cur_q + IDX_W'(1);
									sleft_d = sleft_q - LEN_W'(1);
									stage_d = (sleft_q == LEN_W'(1)) ? ST_TRAIL : ST_SLEN;
								end else begin
									sbl_d = w[LEN_W-1:0];
									stage_d = ST_DATA;
								end
							end
						end
					end
					ST_DATA: begin
						res.have = 1'b1;
						res.data_valid = 1'b1;
						res.data_byte = byte_in;
						res.string_index = cur_q;
						if (in_name) begin
							if (name_byte(NAME_GET, pos) != byte_in) match_d[MATCH_GET] = 1'b0;
							if (name_byte(NAME_SET, pos) != byte_in) match_d[MATCH_SET] = 1'b0;
							if (name_byte(NAME_DEL, pos) != byte_in) match_d[MATCH_DEL] = 1'b0;
						end
						sbl_d = sbl_q - LEN_W'(1);
						if (sbl_q == LEN_W'(1)) begin
							res.string_last = 1'b1;
							cur_d = cur_q + IDX_W'(1);
							sleft_d = sleft_q - LEN_W'(1);
							stage_d = (sleft_q == LEN_W'(1)) ? ST_TRAIL : ST_SLEN;
						end
					end
					default: begin
						err_d = 1'b1;
					end
				endcase

				if (last) begin
					ok = !err_d && stage_d == ST_TRAIL;
					res.have = 1'b1;
					res.frame_end = 1'b1;
					res.verdict = ok ? VERDICT_OK : VERDICT_MALFORMED;
					res.command = ok ? classify(total_d, match_d) : CMD_GET;
					stage_d = ok ? ST_LEN : ST_CLOSED;
					hcnt_d = 2'd0;
					word_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_LEN;
			hcnt_q <= 2'd0;
			word_q <= '0;
			fbl_q <= '0;
			sleft_q <= '0;
			total_q <= '0;
			sbl_q <= '0;
			cur_q <= '0;
			err_q <= 1'b0;
			match_q <= MATCH_ALL;
		end else begin
			stage_q <= stage_d;
			hcnt_q <= hcnt_d;
			word_q <= word_d;
			fbl_q <= fbl_d;
			sleft_q <= sleft_d;
			total_q <= total_d;
			sbl_q <= sbl_d;
			cur_q <= cur_d;
			err_q <= err_d;
			match_q <= match_d;
		end
	end

	a_closed_stays: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q == ST_CLOSED |=> stage_q == ST_CLOSED)
		else $error("Closed stream reopened.");

	a_frame_end_resync: assert property (@(posedge clk) disable iff (!arst_n)
		res.frame_end |=> (stage_q == ST_LEN || stage_q == ST_CLOSED) && hcnt_q == 2'd0)
		else $error("Frame end did not return to the length header.");

	a_too_long_from_len: assert property (@(posedge clk) disable iff (!arst_n)
		res.frame_end && res.verdict == VERDICT_TOO_LONG |-> stage_q == ST_LEN)
		else $error("Too-long verdict outside the frame length header.");

	a_frame_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_q == ST_CNT || stage_q == ST_SLEN || stage_q == ST_DATA
			|| stage_q == ST_TRAIL) |-> fbl_q != '0)
		else $error("Inside a frame with no frame bytes left.");

	a_data_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q == ST_DATA |-> sbl_q != '0 && sbl_q <= fbl_q)
		else $error("String data runs past the frame.");

endmodule

>>> verif/tb_length_prefixed_request_deframer.sv
`timescale 1ns / 1ps
// Self-checking testbench of the length-prefixed request deframer driven with random framed requests.
module tb_length_prefixed_request_deframer;
	import lprd_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int PHASE_BYTES = 270;

	typedef logic [7:0] bytes_t[$];

	typedef enum logic [2:0] {
		AWAIT_LEN,
		AWAIT_COUNT,
		AWAIT_STRLEN,
		IN_STRING,
		AWAIT_END,
		SHUT
	} parse_stage_t;

	typedef struct packed {
		logic             data_valid;
		logic [7:0]       data_byte;
		logic [IDX_W-1:0] string_index;
		logic             string_last;
		logic             frame_end;
		verdict_t         verdict;
		command_t         command;
	} deframe_result_t;

	class deframe_book;
		logic [LEN_W-1:0]  limit;
		parse_stage_t      stage;
		logic [1:0]        hdr_count;
		logic [WORD_W-1:0] word_acc;
		logic [WORD_W-1:0] frame_left;
		logic [LEN_W-1:0]  strings_left;
		logic [LEN_W-1:0]  string_total;
		logic [WORD_W-1:0] string_bytes;
		logic [IDX_W-1:0]  cur_string;
		bit                flagged;
		logic [2:0]        candidates;
		deframe_result_t   awaited[$];
		int                errors;

		function new();
			limit = MAX_LEN_RESET;
			stage = AWAIT_LEN;
			hdr_count = '0;
			word_acc = '0;
			frame_left = '0;
			strings_left = '0;
			string_total = '0;
			string_bytes = '0;
			cur_string = '0;
			flagged = 1'b0;
			candidates = MATCH_ALL;
			errors = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function bit take_header(logic [7:0] b);
			word_acc = word_acc | (WORD_W'(b) << (8 * hdr_count));
			hdr_count = hdr_count + 2'd1;
			return hdr_count == 2'd0;
		endfunction

		function void clear_header();
			hdr_count = '0;
			word_acc = '0;
		endfunction

		function void advance_string();
			cur_string = cur_string + 1'b1;
			strings_left = strings_left - 1'b1;
			stage = (strings_left == '0) ? AWAIT_END : AWAIT_STRLEN;
		endfunction

		function command_t command_class();
			if (string_total == LEN_W'(2) && candidates[MATCH_GET]) return CMD_GET;
			if (string_total == LEN_W'(3) && candidates[MATCH_SET]) return CMD_SET;
			if (string_total == LEN_W'(2) && candidates[MATCH_DEL]) return CMD_DEL;
			return CMD_UNKNOWN;
		endfunction

		function void absorb_byte(logic [7:0] b);
			deframe_result_t r;
			bit have;
			bit last;
			bit ok;
			logic [WORD_W-1:0] w;
			int shift;
			r = '0;
			have = 1'b0;
			if (stage == SHUT) return;
			if (stage == AWAIT_LEN) begin
				if (!take_header(b)) return;
				w = word_acc;
				clear_header();
				if (w > limit || w == '0) begin
					stage = SHUT;
					have = 1'b1;
					r.frame_end = 1'b1;
					r.verdict = (w == '0) ? VERDICT_MALFORMED : VERDICT_TOO_LONG;
				end else begin
					frame_left = w;
					stage = AWAIT_COUNT;
					flagged = 1'b0;
					candidates = MATCH_ALL;
					strings_left = '0;
					string_total = '0;
					cur_string = '0;
					string_bytes = '0;
					return;
				end
			end else begin
				frame_left = frame_left - 1'b1;
				last = (frame_left == '0);
				case (stage)
					AWAIT_COUNT: begin
						if (take_header(b)) begin
							w = word_acc;
							clear_header();
							if (w > limit) begin
								flagged = 1'b1;
								stage = AWAIT_END;
							end else begin
								strings_left = w[LEN_W-1:0];
								string_total = w[LEN_W-1:0];
								cur_string = '0;
								stage = (w == '0) ? AWAIT_END : AWAIT_STRLEN;
							end
						end
					end
					AWAIT_STRLEN: begin
						if (take_header(b)) begin
							w = word_acc;
							clear_header();
							if (w > frame_left) begin
								flagged = 1'b1;
								stage = AWAIT_END;
							end else begin
								if (cur_string == '0 && w != NAME_LEN) candidates = '0;
								if (w == '0) begin
									have = 1'b1;
									r.string_index = cur_string;
									r.string_last = 1'b1;
									advance_string();
								end else begin
									string_bytes = w;
									stage = IN_STRING;
								end
							end
						end
					end
					IN_STRING: begin
						have = 1'b1;
						r.data_valid = 1'b1;
						r.data_byte = b;
						r.string_index = cur_string;
						if (cur_string == '0 && string_bytes >= 1 && string_bytes <= 3) begin
							shift = 8 * (string_bytes - 1);
							if (b != 8'(NAME_GET >> shift)) candidates[MATCH_GET] = 1'b0;
							if (b != 8'(NAME_SET >> shift)) candidates[MATCH_SET] = 1'b0;
							if (b != 8'(NAME_DEL >> shift)) candidates[MATCH_DEL] = 1'b0;
						end
						string_bytes = string_bytes - 1'b1;
						if (string_bytes == '0) begin
							r.string_last = 1'b1;
							advance_string();
						end
					end
					default: flagged = 1'b1;
				endcase
				if (last) begin
					ok = !flagged && stage == AWAIT_END;
					have = 1'b1;
					r.frame_end = 1'b1;
					r.verdict = ok ? VERDICT_OK : VERDICT_MALFORMED;
					r.command = ok ? command_class() : CMD_GET;
					stage = ok ? AWAIT_LEN : SHUT;
					clear_header();
				end
			end
			if (have) awaited = {awaited, r};
		endfunction

		task flag_mismatch(string what);
			$display("%0t: mismatch: %s", $time, what);
			errors++;
		endtask

		task compare_result(deframe_result_t got);
			deframe_result_t want;
			if (awaited.size() == 0) begin
				flag_mismatch($sformatf("result with none awaited, byte %h index %0d end %b",
					got.data_byte, got.string_index, got.frame_end));
				return;
			end
			want = awaited.pop_front();
			if (got.data_valid !== want.data_valid)
				flag_mismatch($sformatf("data_valid %b, want %b", got.data_valid, want.data_valid));
			if (got.data_byte !== want.data_byte)
				flag_mismatch($sformatf("data_byte %h, want %h", got.data_byte, want.data_byte));
			if (got.string_index !== want.string_index)
				flag_mismatch($sformatf("string_index %0d, want %0d",
					got.string_index, want.string_index));
			if (got.string_last !== want.string_last)
				flag_mismatch($sformatf("string_last %b, want %b", got.string_last, want.string_last));
			if (got.frame_end !== want.frame_end)
				flag_mismatch($sformatf("frame_end %b, want %b", got.frame_end, want.frame_end));
			if (got.verdict !== want.verdict)
				flag_mismatch($sformatf("verdict %0d, want %0d", got.verdict, want.verdict));
			if (got.command !== want.command)
				flag_mismatch($sformatf("command %0d, want %0d", got.command, want.command));
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [LEN_W-1:0] max_message_length = MAX_LEN_RESET;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [7:0]       stream_byte = 8'h00;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic             data_valid;
	logic [7:0]       data_byte;
	logic [IDX_W-1:0] string_index;
	logic             string_last;
	logic             frame_end;
	logic [1:0]       verdict;
	logic [1:0]       command;

	deframe_book book;
	bit in_quiet = 1'b0;
	bit out_quiet = 1'b0;
	int hold = 0;
	int quiet_cycles = 0;
	int sent_bytes = 0;

	length_prefixed_request_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.max_message_length(max_message_length),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stream_byte(stream_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_valid(data_valid),
		.data_byte(data_byte),
		.string_index(string_index),
		.string_last(string_last),
		.frame_end(frame_end),
		.verdict(verdict),
		.command(command)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		deframe_result_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.data_valid = data_valid;
				got.data_byte = data_byte;
				got.string_index = string_index;
				got.string_last = string_last;
				got.frame_end = frame_end;
				got.verdict = verdict_t'(verdict);
				got.command = command_t'(command);
				book.compare_result(got);
				hold = out_quiet ? 0 : $urandom_range(0, 11);
			end
			out_stall <= (hold != 0);
			if (hold != 0) hold--;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("tb_length_prefixed_request_deframer failed");
			$finish;
		end
	end

	function automatic void put_word(ref bytes_t q, input logic [31:0] w);
		for (int i = 0; i < 4; i++) q = {q, w[8*i +: 8]};
	endfunction

	function automatic void put_string(ref bytes_t q, input bytes_t s);
		put_word(q, s.size());
		foreach (s[i]) q = {q, s[i]};
	endfunction

	function automatic bytes_t rand_bytes(input int len);
		bytes_t s;
		s = {};
		for (int i = 0; i < len; i++) s = {s, 8'($urandom_range(0, 255))};
		return s;
	endfunction

	function automatic bytes_t name_str(input logic [23:0] name);
		bytes_t s;
		s = {};
		s = {s, name[23:16]};
		s = {s, name[15:8]};
		s = {s, name[7:0]};
		return s;
	endfunction

	function automatic bytes_t frame_of(input bytes_t body);
		bytes_t q;
		q = {};
		put_word(q, body.size());
		foreach (body[i]) q = {q, body[i]};
		return q;
	endfunction

	// Mostly well-formed requests; some carry near-miss names or odd argument counts.
	function automatic bytes_t request_body(input logic [31:0] lim);
		bytes_t body;
		bytes_t s;
		int kind;
		int n;
		logic [23:0] name;
		kind = $urandom_range(0, 7);
		case ($urandom_range(0, 2))
			0: name = NAME_GET;
			1: name = NAME_SET;
			default: name = NAME_DEL;
		endcase
		case (kind)
			0: begin
				name = NAME_GET;
				n = 2;
			end
			1: begin
				name = NAME_SET;
				n = 3;
			end
			2: begin
				name = NAME_DEL;
				n = 2;
			end
			default: n = $urandom_range(kind >= 6 ? 0 : 1, 5);
		endcase
		body = {};
		put_word(body, n);
		for (int i = 0; i < n; i++) begin
			if (i == 0 && kind < 6) begin
				s = name_str(name);
				if (kind == 3) s[$urandom_range(0, 2)] ^= 8'($urandom_range(1, 255));
				if (kind == 5) begin
					if ($urandom_range(0, 1) == 1) void'(s.pop_back());
					else s = {s, 8'($urandom_range(0, 255))};
				end
			end else begin
				s = rand_bytes($urandom_range(0, 3) == 0 ? $urandom_range(7, 24)
					: $urandom_range(0, 6));
			end
			put_string(body, s);
		end
		if (body.size() > lim) begin
			body = {};
			put_word(body, 0);
		end
		return body;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = in_quiet ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (in_stall);
		sent_bytes++;
		book.absorb_byte(b);
	endtask

	task automatic send_bytes(input bytes_t q);
		foreach (q[i]) send_byte(q[i]);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_limit(input logic [31:0] v);
		cfg_valid <= 1'b1;
		max_message_length <= v[LEN_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		book.limit = v[LEN_W-1:0];
	endtask

	task automatic run_frames(input logic [31:0] lim, input int budget);
		int first;
		bytes_t body;
		first = sent_bytes;
		while (sent_bytes - first < budget) begin
			in_quiet = ($urandom_range(0, 3) == 0);
			out_quiet = ($urandom_range(0, 3) == 0);
			if (lim <= 80 && $urandom_range(0, 5) == 0) begin
				body = {};
				put_word(body, 1);
				put_string(body, rand_bytes(lim - 8));
			end else begin
				body = request_body(lim);
			end
			send_bytes(frame_of(body));
			if ($urandom_range(0, 9) == 0) settle();
		end
	endtask

	// One fatal frame ends the traffic; the bytes after it must be dropped silently.
	task automatic close_stream();
		bytes_t q;
		bytes_t body;
		int k;
		logic [31:0] lim;
		q = {};
		body = {};
		k = $urandom_range(0, 6);
		case ($urandom_range(0, 7))
			0: begin
				lim = $urandom_range(4, 5000);
				write_limit(lim);
				put_word(q, $urandom_range(0, 1) == 1 ? lim + 1 : 32'hFFFF_FFFF);
			end
			1: put_word(q, 0);
			2: begin
				write_limit(64);
				put_word(q, 4 + k);
				put_word(q, 65 + $urandom_range(0, 1000));
				q = {q, rand_bytes(k)};
			end
			3: begin
				put_word(q, 12 + k);
				put_word(q, 1);
				put_word(q, k + 1 + $urandom_range(0, 9));
				q = {q, rand_bytes(k)};
			end
			4: begin
				put_word(body, 1);
				put_string(body, rand_bytes(3));
				body = {body, rand_bytes($urandom_range(1, 5))};
				q = frame_of(body);
			end
			5: begin
				k = $urandom_range(1, 3);
				if ($urandom_range(0, 1) == 1) begin
					put_word(q, k);
					q = {q, rand_bytes(k)};
				end else begin
					put_word(q, 4 + k);
					put_word(q, 1);
					q = {q, rand_bytes(k)};
				end
			end
			6: begin
				write_limit(0);
				put_word(body, 0);
				q = frame_of(body);
			end
			default: begin
				write_limit(1);
				put_word(q, 1);
				q = {q, rand_bytes(1)};
			end
		endcase
		send_bytes(q);
		settle();
		send_bytes(rand_bytes(16));
	endtask

	initial begin
		bytes_t body;
		bytes_t key;
		logic [31:0] lims[4];
		book = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		body = {};
		put_word(body, 0);
		send_bytes(frame_of(body));
		key = {};
		key = {key, 8'h00};
		key = {key, 8'hFF};
		body = {};
		put_word(body, 2);
		put_string(body, name_str(NAME_GET));
		put_string(body, key);
		send_bytes(frame_of(body));
		settle();

		lims[0] = 32'd33554432;
		lims[1] = 32'd33554431;
		lims[2] = 32'd40;
		lims[3] = $urandom_range(48, 4096);
		foreach (lims[i]) begin
			write_limit(lims[i]);
			run_frames(lims[i], PHASE_BYTES);
			settle();
		end

		close_stream();
		settle();
		if (book.errors == 0)
			$display("tb_length_prefixed_request_deframer passed");
		else
			$display("tb_length_prefixed_request_deframer failed");
		$finish;
	end

endmodule
